// File: design/tgsd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package tgsd_pkg;

  // Sizing
  localparam int MAX_FINGERS = 5;
  localparam int COORD_BITS  = 16;
  localparam int FIELD_W     = 16;
  localparam int THR_W       = 16;
  localparam int AVG_W       = 17;
  localparam int CNT_OUT_W   = 3;
  localparam int CNT_W       = $clog2(MAX_FINGERS + 1);
  localparam int IDX_W       = (MAX_FINGERS > 1) ? $clog2(MAX_FINGERS) : 1;
  localparam int MAG_W       = COORD_BITS + $clog2(MAX_FINGERS);
  localparam int SUM_W       = MAG_W + 1;
  localparam int DCNT_W      = $clog2(MAG_W + 1);
  localparam int LIM_W       = THR_W + CNT_W;
  localparam int MUL_W       = (MAG_W > LIM_W) ? MAG_W : LIM_W;
  localparam int SQ_W        = 2 * MUL_W + 2;
  localparam int SQI_W       = 3;
  localparam int SQ_STEPS    = 4;
  localparam int PADDR_W     = 3;
  localparam int PDATA_W     = 32;

  localparam logic [THR_W-1:0] LOW_THR_RESET  = THR_W'(50);
  localparam logic [THR_W-1:0] HIGH_THR_RESET = THR_W'(200);

  // Register index (paddr[2])
  localparam logic REG_LOW  = 1'b0;
  localparam logic REG_HIGH = 1'b1;

  typedef logic [COORD_BITS-1:0] coord_t;
  typedef logic [2:0][COORD_BITS-1:0] point_t;

  typedef enum logic [1:0] {
    EV_START = 2'd0,
    EV_MOVE  = 2'd1,
    EV_STOP  = 2'd2
  } event_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_STOP,
    ST_UPDATE,
    ST_COPY,
    ST_SUM,
    ST_DIV,
    ST_SQ,
    ST_TEST,
    ST_EMIT_START,
    ST_EMIT_MOVE
  } state_t;

  typedef struct packed {
    logic   in_take;
    logic   hands_off;
    logic   restart;
    logic   walk_init;
    logic   walk_copy;
    logic   walk_sum;
    logic   div_start;
    logic   div_step;
    logic   avg_load;
    logic   sq_step;
    logic   set_met;
    logic   end_frame;
    logic   out_load;
    event_t out_event;
    logic   out_last;
  } dp_cmd_t;

  typedef struct packed {
    logic fcount_zero;
    logic met;
    logic need_stop;
    logic restart_need;
    logic walk_done;
    logic div_done;
    logic sq_done;
    logic over;
    logic out_free;
  } dp_status_t;

endpackage
`default_nettype wire

// File: design/tgsd_if.sv
`timescale 1ns / 1ps
`default_nettype none
// Point channel
interface tgsd_in_if;
  logic                        valid;
  logic                        ready;
  logic [tgsd_pkg::FIELD_W-1:0] point_x;
  logic [tgsd_pkg::FIELD_W-1:0] point_y;
  logic [tgsd_pkg::FIELD_W-1:0] point_z;
  logic                        frame_end;
  logic                        frame_empty;
  modport source(output valid, point_x, point_y, point_z, frame_end, frame_empty,
                 input ready);
  modport sink(input valid, point_x, point_y, point_z, frame_end, frame_empty,
               output ready);
endinterface

// Event channel
interface tgsd_out_if;
  logic                          valid;
  logic                          ready;
  logic [1:0]                    event_res;
  logic [tgsd_pkg::CNT_OUT_W-1:0] finger_count;
  logic signed [tgsd_pkg::AVG_W-1:0] avg_dx;
  logic signed [tgsd_pkg::AVG_W-1:0] avg_dy;
  logic signed [tgsd_pkg::AVG_W-1:0] avg_dz;
  logic                          last_result;
  modport source(output valid, event_res, finger_count, avg_dx, avg_dy, avg_dz,
                 last_result, input ready);
  modport sink(input valid, event_res, finger_count, avg_dx, avg_dy, avg_dz,
               last_result, output ready);
endinterface
`default_nettype wire

// File: design/tgsd_regs.sv
`timescale 1ns / 1ps
`default_nettype none
module tgsd_regs (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [tgsd_pkg::PADDR_W-1:0]   paddr,
  input  wire logic [tgsd_pkg::PDATA_W-1:0]   pwdata,
  output logic      [tgsd_pkg::PDATA_W-1:0]   prdata,
  output logic                                pready,
  output logic      [tgsd_pkg::THR_W-1:0]     low_threshold,
  output logic      [tgsd_pkg::THR_W-1:0]     high_threshold
);

  logic wr_en;
  assign wr_en  = psel & penable & pwrite;
  assign pready = 1'b1;

  // Threshold registers
  always_ff @(posedge clk) begin
    if (rst) begin
      low_threshold  <= tgsd_pkg::LOW_THR_RESET;
      high_threshold <= tgsd_pkg::HIGH_THR_RESET;
    end else if (wr_en) begin
      if (paddr[2] == tgsd_pkg::REG_LOW) begin
        low_threshold <= pwdata[tgsd_pkg::THR_W-1:0];
      end else begin
        high_threshold <= pwdata[tgsd_pkg::THR_W-1:0];
      end
    end
  end

  // Read mux
  always_comb begin
    if (paddr[2] == tgsd_pkg::REG_HIGH) begin
      prdata = tgsd_pkg::PDATA_W'(high_threshold);
    end else begin
      prdata = tgsd_pkg::PDATA_W'(low_threshold);
    end
  end

endmodule
`default_nettype wire

// File: design/tgsd_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
module tgsd_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  input  wire logic                 in_frame_end,
  output logic                      in_ready,
  input  wire tgsd_pkg::dp_status_t status,
  output tgsd_pkg::dp_cmd_t         cmd
);

  tgsd_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tgsd_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      tgsd_pkg::ST_IDLE: begin
        if (in_valid && in_frame_end) state_next = tgsd_pkg::ST_DECIDE;
      end
      tgsd_pkg::ST_DECIDE: begin
        state_next = status.need_stop ? tgsd_pkg::ST_STOP : tgsd_pkg::ST_UPDATE;
      end
      tgsd_pkg::ST_STOP: begin
        if (status.out_free) state_next = tgsd_pkg::ST_UPDATE;
      end
      tgsd_pkg::ST_UPDATE: begin
        priority if (status.fcount_zero) state_next = tgsd_pkg::ST_IDLE;
        else if (status.restart_need) state_next = tgsd_pkg::ST_COPY;
        else state_next = tgsd_pkg::ST_SUM;
      end
      tgsd_pkg::ST_COPY: begin
        if (status.walk_done) state_next = tgsd_pkg::ST_IDLE;
      end
      tgsd_pkg::ST_SUM: begin
        if (status.walk_done) state_next = tgsd_pkg::ST_DIV;
      end
      tgsd_pkg::ST_DIV: begin
        if (status.div_done) begin
          state_next = status.met ? tgsd_pkg::ST_EMIT_MOVE : tgsd_pkg::ST_SQ;
        end
      end
      tgsd_pkg::ST_SQ: begin
        if (status.sq_done) state_next = tgsd_pkg::ST_TEST;
      end
      tgsd_pkg::ST_TEST: begin
        state_next = status.over ? tgsd_pkg::ST_EMIT_START : tgsd_pkg::ST_IDLE;
      end
      tgsd_pkg::ST_EMIT_START: begin
        if (status.out_free) state_next = tgsd_pkg::ST_EMIT_MOVE;
      end
      tgsd_pkg::ST_EMIT_MOVE: begin
        if (status.out_free) state_next = tgsd_pkg::ST_IDLE;
      end
      default: state_next = tgsd_pkg::ST_IDLE;
    endcase
  end

  // Commands
  always_comb begin
    cmd           = '0;
    cmd.out_event = tgsd_pkg::EV_MOVE;
    in_ready      = 1'b0;
    unique case (state)
      tgsd_pkg::ST_IDLE: begin
        in_ready    = 1'b1;
        cmd.in_take = in_valid;
      end
      tgsd_pkg::ST_DECIDE: begin
      end
      tgsd_pkg::ST_STOP: begin
        cmd.out_load  = status.out_free;
        cmd.out_event = tgsd_pkg::EV_STOP;
        cmd.out_last  = 1'b1;
      end
      tgsd_pkg::ST_UPDATE: begin
        priority if (status.fcount_zero) cmd.hands_off = 1'b1;
        else if (status.restart_need) cmd.restart = 1'b1;
        else cmd.walk_init = 1'b1;
      end
      tgsd_pkg::ST_COPY: begin
        cmd.walk_copy = !status.walk_done;
        cmd.end_frame = status.walk_done;
      end
      tgsd_pkg::ST_SUM: begin
        cmd.walk_sum  = !status.walk_done;
        cmd.div_start = status.walk_done;
      end
      tgsd_pkg::ST_DIV: begin
        cmd.div_step = !status.div_done;
        cmd.avg_load = status.div_done;
      end
      tgsd_pkg::ST_SQ: begin
        cmd.sq_step = !status.sq_done;
      end
      tgsd_pkg::ST_TEST: begin
        cmd.set_met   = status.over;
        cmd.end_frame = !status.over;
      end
      tgsd_pkg::ST_EMIT_START: begin
        cmd.out_load  = status.out_free;
        cmd.out_event = tgsd_pkg::EV_START;
      end
      tgsd_pkg::ST_EMIT_MOVE: begin
        cmd.out_load  = status.out_free;
        cmd.out_event = tgsd_pkg::EV_MOVE;
        cmd.out_last  = 1'b1;
        cmd.end_frame = status.out_free;
      end
      default: begin
      end
    endcase
  end

endmodule
`default_nettype wire

// File: design/tgsd_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
module tgsd_datapath (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire tgsd_pkg::dp_cmd_t                 cmd,
  output tgsd_pkg::dp_status_t                   status,
  input  wire logic [tgsd_pkg::FIELD_W-1:0]      point_x,
  input  wire logic [tgsd_pkg::FIELD_W-1:0]      point_y,
  input  wire logic [tgsd_pkg::FIELD_W-1:0]      point_z,
  input  wire logic                              frame_empty,
  input  wire logic [tgsd_pkg::THR_W-1:0]        low_threshold,
  input  wire logic [tgsd_pkg::THR_W-1:0]        high_threshold,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic [1:0]                             event_res,
  output logic [tgsd_pkg::CNT_OUT_W-1:0]         finger_count,
  output logic signed [tgsd_pkg::AVG_W-1:0]      avg_dx,
  output logic signed [tgsd_pkg::AVG_W-1:0]      avg_dy,
  output logic signed [tgsd_pkg::AVG_W-1:0]      avg_dz,
  output logic                                   last_result
);

  localparam int NF = tgsd_pkg::MAX_FINGERS;
  localparam int MW = tgsd_pkg::MAG_W;
  localparam int CW = tgsd_pkg::CNT_W;

  // Point buffers
  tgsd_pkg::point_t frame_pts [NF];
  tgsd_pkg::point_t start_pts [NF];

  // Gesture state
  logic [CW-1:0] fcount;
  logic [CW-1:0] gcount;
  logic          active;
  logic          met;
  logic          use_high;
  logic signed [tgsd_pkg::AVG_W-1:0] last_avg [3];

  // Walk, divide and square sequencing
  logic [CW-1:0]                   walk_idx;
  logic [tgsd_pkg::DCNT_W-1:0]     div_cnt;
  logic [tgsd_pkg::SQI_W-1:0]      sq_idx;
  logic signed [tgsd_pkg::SUM_W-1:0] acc [3];
  logic [MW-1:0]                   mag_r [3];
  logic                            neg_r [3];
  logic [MW-1:0]                   work [3];
  logic [CW-1:0]                   rem [3];
  logic [tgsd_pkg::LIM_W-1:0]      lim_r;
  logic [2*tgsd_pkg::MUL_W-1:0]    prod;
  logic [tgsd_pkg::SQ_W-1:0]       acc_sq;

  logic                          take_point;
  tgsd_pkg::point_t              in_pt;
  tgsd_pkg::point_t              rd_f;
  tgsd_pkg::point_t              rd_s;
  logic signed [tgsd_pkg::COORD_BITS:0] delta [3];
  logic [MW-1:0]                 mag_c [3];
  logic [CW:0]                   trial [3];
  logic                          qbit [3];
  logic signed [MW:0]            qs [3];
  logic signed [tgsd_pkg::AVG_W-1:0] avg_c [3];
  logic [tgsd_pkg::MUL_W-1:0]    sq_op;
  logic [tgsd_pkg::THR_W-1:0]    thr_sel;

  assign take_point = cmd.in_take && !frame_empty && (fcount < CW'(NF));
  assign in_pt[0]   = tgsd_pkg::coord_t'(point_x);
  assign in_pt[1]   = tgsd_pkg::coord_t'(point_y);
  assign in_pt[2]   = tgsd_pkg::coord_t'(point_z);
  assign rd_f       = frame_pts[walk_idx[tgsd_pkg::IDX_W-1:0]];
  assign rd_s       = start_pts[walk_idx[tgsd_pkg::IDX_W-1:0]];
  assign thr_sel    = use_high ? high_threshold : low_threshold;

  // Per-lane delta, magnitude, divide step and signed average
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      delta[k] = $signed({1'b0, rd_f[k]}) - $signed({1'b0, rd_s[k]});
      mag_c[k] = acc[k][tgsd_pkg::SUM_W-1] ? MW'(-acc[k]) : MW'(acc[k]);
      trial[k] = {rem[k], work[k][MW-1]};
      qbit[k]  = (trial[k] >= {1'b0, gcount});
      qs[k]    = $signed({1'b0, work[k]});
      avg_c[k] = neg_r[k] ? tgsd_pkg::AVG_W'(-qs[k]) : tgsd_pkg::AVG_W'(qs[k]);
    end
  end

  // Square operand select
  always_comb begin
    unique case (sq_idx)
      3'd0:    sq_op = tgsd_pkg::MUL_W'(mag_r[0]);
      3'd1:    sq_op = tgsd_pkg::MUL_W'(mag_r[1]);
      3'd2:    sq_op = tgsd_pkg::MUL_W'(mag_r[2]);
      default: sq_op = tgsd_pkg::MUL_W'(lim_r);
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      fcount    <= '0;
      gcount    <= '0;
      active    <= 1'b0;
      met       <= 1'b0;
      use_high  <= 1'b0;
      walk_idx  <= '0;
      div_cnt   <= '0;
      sq_idx    <= '0;
      out_valid <= 1'b0;
      for (int k = 0; k < 3; k++) last_avg[k] <= '0;
    end else begin
      if (take_point) fcount <= fcount + 1'b1;
      if (cmd.hands_off) begin
        active   <= 1'b0;
        use_high <= 1'b0;
        fcount   <= '0;
      end
      if (cmd.restart) begin
        active   <= 1'b1;
        gcount   <= fcount;
        met      <= 1'b0;
        walk_idx <= '0;
        if (active && (gcount > fcount)) use_high <= 1'b1;
        for (int k = 0; k < 3; k++) last_avg[k] <= '0;
      end
      if (cmd.walk_init) walk_idx <= '0;
      if (cmd.walk_copy || cmd.walk_sum) walk_idx <= walk_idx + 1'b1;
      if (cmd.div_start) begin
        div_cnt <= '0;
        sq_idx  <= '0;
      end
      if (cmd.div_step) div_cnt <= div_cnt + 1'b1;
      if (cmd.avg_load) begin
        for (int k = 0; k < 3; k++) last_avg[k] <= avg_c[k];
      end
      if (cmd.sq_step) sq_idx <= sq_idx + 1'b1;
      if (cmd.set_met) met <= 1'b1;
      if (cmd.end_frame) fcount <= '0;
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload storage and arithmetic
  always_ff @(posedge clk) begin
    if (take_point) frame_pts[fcount[tgsd_pkg::IDX_W-1:0]] <= in_pt;
    if (cmd.walk_copy) start_pts[walk_idx[tgsd_pkg::IDX_W-1:0]] <= rd_f;
    if (cmd.walk_init) begin
      for (int k = 0; k < 3; k++) acc[k] <= '0;
    end
    if (cmd.walk_sum) begin
      for (int k = 0; k < 3; k++) acc[k] <= acc[k] + tgsd_pkg::SUM_W'(delta[k]);
    end
    if (cmd.div_start) begin
      for (int k = 0; k < 3; k++) begin
        mag_r[k] <= mag_c[k];
        neg_r[k] <= acc[k][tgsd_pkg::SUM_W-1];
        work[k]  <= mag_c[k];
        rem[k]   <= '0;
      end
      lim_r  <= thr_sel * gcount;
      acc_sq <= '0;
    end
    if (cmd.div_step) begin
      for (int k = 0; k < 3; k++) begin
        rem[k]  <= qbit[k] ? CW'(trial[k] - {1'b0, gcount}) : trial[k][CW-1:0];
        work[k] <= {work[k][MW-2:0], qbit[k]};
      end
    end
    if (cmd.sq_step) begin
      prod <= sq_op * sq_op;
      if (sq_idx != '0) acc_sq <= acc_sq + tgsd_pkg::SQ_W'(prod);
    end
    if (cmd.out_load) begin
      event_res    <= cmd.out_event;
      finger_count <= tgsd_pkg::CNT_OUT_W'(gcount);
      avg_dx       <= last_avg[0];
      avg_dy       <= last_avg[1];
      avg_dz       <= last_avg[2];
      last_result  <= cmd.out_last;
    end
  end

  // Status to controller
  always_comb begin
    status.fcount_zero  = (fcount == '0);
    status.met          = met;
    status.need_stop    = active && met && ((fcount == '0) || (gcount != fcount));
    status.restart_need = !active || (gcount != fcount);
    status.walk_done    = (walk_idx == gcount);
    status.div_done     = (div_cnt == tgsd_pkg::DCNT_W'(MW));
    status.sq_done      = (sq_idx == tgsd_pkg::SQI_W'(tgsd_pkg::SQ_STEPS));
    status.over         = (acc_sq > tgsd_pkg::SQ_W'(prod));
    status.out_free     = !out_valid || out_ready;
  end

  // A pending result is never overwritten
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> (!out_valid || out_ready))
    else $error("result register overwritten");

  // Walk never runs past the gesture's finger count
  a_walk_bound: assert property (@(posedge clk) disable iff (rst)
    (cmd.walk_copy || cmd.walk_sum) |-> (walk_idx < gcount))
    else $error("walk index past finger count");

  // Frame buffer fill stays within capacity
  a_fcount_bound: assert property (@(posedge clk) disable iff (rst)
    fcount <= CW'(NF))
    else $error("frame count over capacity");

endmodule
`default_nettype wire

// File: design/touch_gesture_start_detector_core.sv
`timescale 1ns / 1ps
`default_nettype none
// Touch gesture start detector.
// points: one finger point per transaction (valid/ready); frame_end marks the
// last transaction of a frame, frame_empty marks a transaction with no point.
// events: start/move/stop results (valid/ready), last_result on the final one
// of a frame. APB port: low_threshold at 0x0, high_threshold at 0x4.
// A point that does not end a frame is taken while the controller is idle.
// A frame end runs a copy of the start points when the finger count changes
// or no gesture is active; otherwise an N-step point walk, a 19-step
// bit-serial divide of the three sums by N, four passes through one squaring
// multiplier and the compare; once the gesture has started the squaring and
// compare are skipped. A hands-off frame clears the gesture state. A stop
// event is loaded before the update; other results wait for a free output.
// The next frame's points are taken while the last result still waits in the
// output register; a stalled receiver holds the controller only when a new
// result must be loaded. Reset clears the gesture state, empties the frame
// buffer and restores thresholds 50 and 200; no clearing pass is needed.
module touch_gesture_start_detector_core (
  input  wire logic                         clk,
  input  wire logic                         rst,
  tgsd_in_if.sink                           points,
  tgsd_out_if.source                        events,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [tgsd_pkg::PADDR_W-1:0] paddr,
  input  wire logic [tgsd_pkg::PDATA_W-1:0] pwdata,
  output logic      [tgsd_pkg::PDATA_W-1:0] prdata,
  output logic                              pready
);

  tgsd_pkg::dp_cmd_t    cmd;
  tgsd_pkg::dp_status_t status;
  logic [tgsd_pkg::THR_W-1:0] low_threshold;
  logic [tgsd_pkg::THR_W-1:0] high_threshold;
  logic in_ready;

  assign points.ready = in_ready;

  tgsd_regs u_regs (
    .clk            (clk),
    .rst            (rst),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .low_threshold  (low_threshold),
    .high_threshold (high_threshold)
  );

  tgsd_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (points.valid),
    .in_frame_end (points.frame_end),
    .in_ready     (in_ready),
    .status       (status),
    .cmd          (cmd)
  );

  tgsd_datapath u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .status         (status),
    .point_x        (points.point_x),
    .point_y        (points.point_y),
    .point_z        (points.point_z),
    .frame_empty    (points.frame_empty),
    .low_threshold  (low_threshold),
    .high_threshold (high_threshold),
    .out_valid      (events.valid),
    .out_ready      (events.ready),
    .event_res      (events.event_res),
    .finger_count   (events.finger_count),
    .avg_dx         (events.avg_dx),
    .avg_dy         (events.avg_dy),
    .avg_dz         (events.avg_dz),
    .last_result    (events.last_result)
  );

endmodule
`default_nettype wire
